@@ rtl/fec_pkg.sv @@
// ----------------------------------------------------------------------------
// Free extent coalescer package
// Shared types and constants for the extent table controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package fec_pkg;
   localparam int TableDepth = 16;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_DUMP   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [2:0] ST_LOADED   = 3'd0;
   localparam logic [2:0] ST_MERGED   = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_LISTED   = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,  // register the request
      OP_READ,     // read entry idx into the read register
      OP_READ2,    // read entry idx and idx+1
      OP_WR_REQ,   // write request extent at idx
      OP_GROW_DN,  // write entry idx with start=req, size=sat(size+len)
      OP_GROW_UP,  // write entry idx with size=sat(size+len)
      OP_SHIFT,    // copy held entry into idx
      OP_MERGE2,   // write entry idx with sat(size + size2)
      OP_COPY_NX   // copy read pair's second entry into idx
   } op_type;

   typedef struct packed {
      op_type         op;
      logic [IdxW-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       abut_dn;   // req top equals entry start
      logic       abut_up;   // entry top equals req start
      logic       above;     // entry start greater than req start
      logic       touch2;    // first entry of pair touches second
   } sts_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/free_extent_coalescer.sv @@
// ----------------------------------------------------------------------------
// Free extent coalescer
// Address-ordered free extent table with load, free and coalescing dump.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load writes the next free entry; a
// free walks the table entry by entry and, if no entry touches the extent, an
// insert finds its place and shifts the later entries up one at a time. A
// dump merges touching neighbours, moving the later entries down over each
// merged one, and then lists the extents. The extent table is accessed once
// per cycle.
`default_nettype none
module free_extent_coalescer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_start_addr,
   input  wire logic [31:0] req_extent_len,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_out_addr,
   output logic [31:0]      rsp_out_len,
   output logic             rsp_last
);
   fec_pkg::cmd_type cmd;
   fec_pkg::sts_type sts;
   logic [31:0] rd_start, rd_size;

   fec_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_action, .sts, .rd_start, .rd_size,
      .cmd, .rsp_valid, .rsp_ready, .rsp_status, .rsp_out_addr, .rsp_out_len, .rsp_last
   );
   fec_datapath u_dp (
      .clock, .cmd, .req_action, .req_start_addr, .req_extent_len, .sts,
      .rd_start, .rd_size
   );
endmodule
`default_nettype wire

@@ rtl/fec_datapath.sv @@
// ----------------------------------------------------------------------------
// Free extent coalescer datapath
// Extent table memory, request register and comparators.
// ----------------------------------------------------------------------------
`default_nettype none
module fec_datapath (
   input  wire logic                    clock,
   input  wire fec_pkg::cmd_type         cmd,
   input  wire logic [1:0]              req_action,
   input  wire logic [31:0]             req_start_addr,
   input  wire logic [31:0]             req_extent_len,
   output fec_pkg::sts_type              sts,
   output logic [31:0]                  rd_start,
   output logic [31:0]                  rd_size
);
   logic [31:0] start_mem [fec_pkg::TableDepth];
   logic [31:0] size_mem  [fec_pkg::TableDepth];
   logic [1:0]  act_ff;
   logic [31:0] pos_ff, len_ff;
   logic [31:0] s0_ff, z0_ff, s1_ff, z1_ff;
   logic [fec_pkg::IdxW-1:0] nxt;
   logic [32:0] req_top, ent_top;

   assign nxt = cmd.idx + 1'b1;
   assign req_top = {1'b0, pos_ff} + {1'b0, len_ff};
   assign ent_top = {1'b0, s0_ff} + {1'b0, z0_ff};

   always_ff @(posedge clock) begin
      if (cmd.op == fec_pkg::OP_CAPTURE) begin
         act_ff <= req_action;
         pos_ff <= req_start_addr;
         len_ff <= req_extent_len;
      end
      if (cmd.op == fec_pkg::OP_READ || cmd.op == fec_pkg::OP_READ2) begin
         s0_ff <= start_mem[cmd.idx];
         z0_ff <= size_mem[cmd.idx];
      end
      if (cmd.op == fec_pkg::OP_READ2) begin
         s1_ff <= start_mem[nxt];
         z1_ff <= size_mem[nxt];
      end
      case (cmd.op)
         fec_pkg::OP_WR_REQ: begin
            start_mem[cmd.idx] <= pos_ff;
            size_mem[cmd.idx]  <= len_ff;
         end
         fec_pkg::OP_GROW_DN: begin
            start_mem[cmd.idx] <= pos_ff;
            size_mem[cmd.idx]  <= fec_pkg::sat_add(z0_ff, len_ff);
         end
         fec_pkg::OP_GROW_UP: size_mem[cmd.idx] <= fec_pkg::sat_add(z0_ff, len_ff);
         fec_pkg::OP_SHIFT: begin
            start_mem[cmd.idx] <= s0_ff;
            size_mem[cmd.idx]  <= z0_ff;
         end
         fec_pkg::OP_MERGE2: size_mem[cmd.idx] <= fec_pkg::sat_add(z0_ff, z1_ff);
         fec_pkg::OP_COPY_NX: begin
            start_mem[cmd.idx] <= s1_ff;
            size_mem[cmd.idx]  <= z1_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      sts.action  = act_ff;
      sts.abut_dn = {1'b0, s0_ff} == req_top;
      sts.abut_up = ent_top == {1'b0, pos_ff};
      sts.above   = s0_ff > pos_ff;
      sts.touch2  = ent_top == {1'b0, s1_ff};
   end
   assign rd_start = s0_ff;
   assign rd_size  = z0_ff;
endmodule
`default_nettype wire

@@ rtl/fec_control.sv @@
// ----------------------------------------------------------------------------
// Free extent coalescer controller
// Sequences table walks, inserts, coalescing and listing.
// ----------------------------------------------------------------------------
`default_nettype none
module fec_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_action,
   input  wire fec_pkg::sts_type  sts,
   input  wire logic [31:0]      rd_start,
   input  wire logic [31:0]      rd_size,
   output fec_pkg::cmd_type       cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_out_addr,
   output logic [31:0]           rsp_out_len,
   output logic                  rsp_last
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_FREE_RD, S_FREE_CHK, S_INS_RD, S_INS_CHK,
      S_SHIFT_RD, S_SHIFT_WR, S_CO_RD, S_CO_CHK, S_CO_MV_RD, S_CO_MV_WR,
      S_LIST_RD, S_LIST_OUT, S_RESP
   } state_type;

   localparam int IW = fec_pkg::IdxW;
   localparam int CW = fec_pkg::CntW;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in, i_ff, i_in, j_ff, j_in, at_ff, at_in;
   logic             full;
   logic [2:0]       rs_load_ff, rs_free_ff;

   assign full = count_ff == CW'(fec_pkg::TableDepth);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      at_in = at_ff;
      cmd.op = fec_pkg::OP_NONE;
      cmd.idx = i_ff[IW-1:0];
      case (state_ff)
         S_IDLE: if (req_valid && req_ready && req_action != fec_pkg::ACT_UNUSED) begin
            cmd.op = fec_pkg::OP_CAPTURE;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            i_in = '0;
            case (sts.action)
               fec_pkg::ACT_LOAD: begin
                  if (!full) begin
                     cmd.op = fec_pkg::OP_WR_REQ;
                     cmd.idx = count_ff[IW-1:0];
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_RESP;
               end
               fec_pkg::ACT_FREE: state_in = S_FREE_RD;
               default: state_in = (count_ff == '0) ? S_RESP : S_CO_RD;
            endcase
         end
         S_FREE_RD: begin
            if (i_ff != count_ff) begin
               cmd.op = fec_pkg::OP_READ;
               state_in = S_FREE_CHK;
            end else if (full) begin
               state_in = S_RESP;
            end else begin
               i_in = '0;
               state_in = S_INS_RD;
            end
         end
         S_FREE_CHK: begin
            if (sts.abut_dn) begin
               cmd.op = fec_pkg::OP_GROW_DN;
               state_in = S_RESP;
            end else if (sts.abut_up) begin
               cmd.op = fec_pkg::OP_GROW_UP;
               state_in = S_RESP;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_FREE_RD;
            end
         end
         S_INS_RD: begin
            if (i_ff == count_ff) begin
               at_in = count_ff;
               j_in = count_ff;
               state_in = S_SHIFT_RD;
            end else begin
               cmd.op = fec_pkg::OP_READ;
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (sts.above) begin
               at_in = i_ff;
               j_in = count_ff;
               state_in = S_SHIFT_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_INS_RD;
            end
         end
         S_SHIFT_RD: begin
            if (j_ff == at_ff) begin
               cmd.op = fec_pkg::OP_WR_REQ;
               cmd.idx = at_ff[IW-1:0];
               count_in = count_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.op = fec_pkg::OP_READ;
               cmd.idx = IW'(j_ff - 1'b1);
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.op = fec_pkg::OP_SHIFT;
            cmd.idx = j_ff[IW-1:0];
            j_in = j_ff - 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_CO_RD: begin
            if (i_ff + 1'b1 >= count_ff) begin
               i_in = '0;
               state_in = S_LIST_RD;
            end else begin
               cmd.op = fec_pkg::OP_READ2;
               state_in = S_CO_CHK;
            end
         end
         S_CO_CHK: begin
            if (sts.touch2) begin
               cmd.op = fec_pkg::OP_MERGE2;
               j_in = i_ff + 1'b1;
               state_in = S_CO_MV_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_CO_RD;
            end
         end
         S_CO_MV_RD: begin
            if (j_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_CO_RD;
            end else begin
               cmd.op = fec_pkg::OP_READ2;
               cmd.idx = j_ff[IW-1:0];
               state_in = S_CO_MV_WR;
            end
         end
         S_CO_MV_WR: begin
            cmd.op = fec_pkg::OP_COPY_NX;
            cmd.idx = j_ff[IW-1:0];
            j_in = j_ff + 1'b1;
            state_in = S_CO_MV_RD;
         end
         S_LIST_RD: begin
            cmd.op = fec_pkg::OP_READ;
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT: if (!rsp_valid) begin
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == count_ff) begin
               count_in = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_LIST_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         at_ff <= '0;
         rsp_valid <= 1'b0;
         rsp_status <= '0;
         rsp_out_addr <= '0;
         rsp_out_len <= '0;
         rsp_last <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         i_ff <= i_in;
         j_ff <= j_in;
         at_ff <= at_in;
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (state_ff == S_RESP && !rsp_valid) begin
            rsp_valid <= 1'b1;
            rsp_out_addr <= '0;
            rsp_out_len <= '0;
            rsp_last <= 1'b1;
            case (sts.action)
               fec_pkg::ACT_LOAD: rsp_status <= rs_load_ff;
               fec_pkg::ACT_FREE: rsp_status <= rs_free_ff;
               default: rsp_status <= fec_pkg::ST_EMPTY;
            endcase
         end
         if (state_ff == S_LIST_OUT && !rsp_valid) begin
            rsp_valid <= 1'b1;
            rsp_status <= fec_pkg::ST_LISTED;
            rsp_out_addr <= rd_start;
            rsp_out_len <= rd_size;
            rsp_last <= (i_ff + 1'b1 == count_ff);
         end
      end
   end

   // Status codes for load and free, settled before the response state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rs_load_ff <= fec_pkg::ST_LOADED;
         rs_free_ff <= fec_pkg::ST_INSERTED;
      end else begin
         if (state_ff == S_DISPATCH)
            rs_load_ff <= full ? fec_pkg::ST_FULL : fec_pkg::ST_LOADED;
         if (state_ff == S_DISPATCH) rs_free_ff <= fec_pkg::ST_INSERTED;
         if (state_ff == S_FREE_CHK && (sts.abut_dn || sts.abut_up))
            rs_free_ff <= fec_pkg::ST_MERGED;
         if (state_ff == S_FREE_RD && i_ff == count_ff && full)
            rs_free_ff <= fec_pkg::ST_FULL;
      end
   end
endmodule
`default_nettype wire

@@ rtl/fec_checker.sv @@
// ----------------------------------------------------------------------------
// Free extent coalescer checker
// Port-level properties of the coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_out_addr,
   input wire logic [31:0] rsp_out_len,
   input wire logic        rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_out_addr) && $stable(rsp_out_len) && $stable(rsp_last))
      else $error("response changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fec_pkg::ST_LISTED |-> rsp_last)
      else $error("status response without last");
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fec_pkg::ST_LISTED |-> rsp_out_addr == '0
      && rsp_out_len == '0)
      else $error("non-zero fields on status response");
endmodule

bind free_extent_coalescer fec_checker u_chk (.*);
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Free extent coalescer testbench
// Drives load, free and dump transactions with random gaps and stalls, works
// out the expected results from its own model of the extent table and checks
// every result transaction field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

class extent_scoreboard;
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] addr;
      logic [31:0] len;
      logic        last;
   } result_type;

   logic [31:0] starts[fec_pkg::TableDepth];
   logic [31:0] sizes[fec_pkg::TableDepth];
   int          count;
   result_type  pending[$];
   int          errors;

   function new();
      count = 0;
      errors = 0;
   endfunction

   function logic [31:0] grow(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      grow = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function void push(logic [2:0] st, logic [31:0] a, logic [31:0] l, logic lst);
      result_type r;
      r.status = st;
      r.addr = a;
      r.len = l;
      r.last = lst;
      pending.push_back(r);
   endfunction

   function logic [2:0] release_extent(logic [31:0] pos, logic [31:0] len);
      logic [32:0] top;
      int at;
      top = {1'b0, pos} + {1'b0, len};
      for (int i = 0; i < count; i++) begin
         if ({1'b0, starts[i]} == top) begin
            starts[i] = pos;
            sizes[i] = grow(sizes[i], len);
            return fec_pkg::ST_MERGED;
         end
         if ({1'b0, starts[i]} + {1'b0, sizes[i]} == {1'b0, pos}) begin
            sizes[i] = grow(sizes[i], len);
            return fec_pkg::ST_MERGED;
         end
      end
      if (count >= fec_pkg::TableDepth) return fec_pkg::ST_FULL;
      at = count;
      for (int i = 0; i < count; i++) begin
         if (starts[i] > pos) begin
            at = i;
            break;
         end
      end
      for (int i = count; i > at; i--) begin
         starts[i] = starts[i-1];
         sizes[i] = sizes[i-1];
      end
      starts[at] = pos;
      sizes[at] = len;
      count++;
      return fec_pkg::ST_INSERTED;
   endfunction

   function void note_request(logic [1:0] act, logic [31:0] pos, logic [31:0] len);
      int t, n;
      if (act == fec_pkg::ACT_LOAD) begin
         if (count >= fec_pkg::TableDepth) begin
            push(fec_pkg::ST_FULL, 0, 0, 1);
         end else begin
            starts[count] = pos;
            sizes[count] = len;
            count++;
            push(fec_pkg::ST_LOADED, 0, 0, 1);
         end
      end else if (act == fec_pkg::ACT_FREE) begin
         push(release_extent(pos, len), 0, 0, 1);
      end else if (act == fec_pkg::ACT_DUMP) begin
         n = count;
         if (n == 0) begin
            push(fec_pkg::ST_EMPTY, 0, 0, 1);
         end else begin
            t = 0;
            while (t + 1 < n) begin
               if ({1'b0, starts[t]} + {1'b0, sizes[t]} == {1'b0, starts[t+1]}) begin
                  sizes[t] = grow(sizes[t], sizes[t+1]);
                  for (int j = t + 1; j + 1 < n; j++) begin
                     starts[j] = starts[j+1];
                     sizes[j] = sizes[j+1];
                  end
                  n--;
               end else begin
                  t++;
               end
            end
            for (int k = 0; k < n; k++)
               push(fec_pkg::ST_LISTED, starts[k], sizes[k], k + 1 == n);
         end
         count = 0;
      end
   endfunction

   function void check_result(logic [2:0] st, logic [31:0] a, logic [31:0] l, logic lst);
      result_type e;
      if (pending.size() == 0) begin
         $error("result transaction with nothing expected");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, st);
         errors++;
      end
      if (a !== e.addr) begin
         $error("out_addr: expected %h, got %h", e.addr, a);
         errors++;
      end
      if (l !== e.len) begin
         $error("out_len: expected %h, got %h", e.len, l);
         errors++;
      end
      if (lst !== e.last) begin
         $error("last: expected %0d, got %0d", e.last, lst);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_action = 0;
   logic [31:0] req_start_addr = 0;
   logic [31:0] req_extent_len = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_out_addr;
   logic [31:0] rsp_out_len;
   logic        rsp_last;

   extent_scoreboard board = new();
   int   quiet_cycles = 0;
   logic [31:0] cursor;

   free_extent_coalescer uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 2));
      return int'($urandom_range(3, 30));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_status, rsp_out_addr, rsp_out_len, rsp_last);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
               $display("free_extent_coalescer: mismatch");
               $finish;
            end
         end
      end
   end

   // The receiver stalls in bursts, with stretches of steady readiness.
   initial begin
      int burst;
      @(negedge clock);
      while (1) begin
         burst = $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1;
            repeat (burst) @(negedge clock);
         end else begin
            repeat (burst) begin
               rsp_ready <= (gap_length() == 0) ? 1'b1 : 1'($urandom_range(0, 1));
               @(negedge clock);
            end
         end
      end
   end

   task automatic send(logic [1:0] act, logic [31:0] pos, logic [31:0] len, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_start_addr <= pos;
      req_extent_len <= len;
      do @(posedge clock); while (!req_ready);
      board.note_request(act, pos, len);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   initial begin
      int n, kind;
      logic [31:0] pos, len;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty dump, free into empty table, extremes, unused code.
      send(fec_pkg::ACT_DUMP, 0, 0, 0);
      send(fec_pkg::ACT_FREE, 32'h100, 32'h10, 0);
      send(fec_pkg::ACT_FREE, 32'hF0, 32'h10, 0);
      send(fec_pkg::ACT_FREE, 32'h110, 32'h8, 0);
      send(fec_pkg::ACT_FREE, 32'h100 - 32'h10, 0, 0);
      send(fec_pkg::ACT_FREE, 32'hF0, 0, 0);
      send(fec_pkg::ACT_FREE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
      send(fec_pkg::ACT_FREE, 32'hFFFF_FFF0, 32'h0000_0100, 0);
      send(fec_pkg::ACT_FREE, 32'h0, 32'h0, 0);
      send(fec_pkg::ACT_LOAD, 32'h50, 32'h10, 0);
      send(fec_pkg::ACT_LOAD, 32'h60, 32'h10, 0);
      send(fec_pkg::ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send(fec_pkg::ACT_DUMP, 0, 0, 0);
      for (int i = 0; i < 17; i++) send(fec_pkg::ACT_LOAD, i * 32'h20, 32'h20, 0);
      send(fec_pkg::ACT_FREE, 32'h1000, 32'h4, 0);
      send(fec_pkg::ACT_FREE, 32'h200, 32'h4, 0);
      send(fec_pkg::ACT_DUMP, 0, 0, 0);
      drain();

      // Random: mostly sequences of abutting extents in a narrow window.
      for (n = 0; n < 320; n++) begin
         if (n == 160) drain();
         kind = $urandom_range(0, 99);
         if (n % 25 == 0) cursor = $urandom;
         len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24);
         if (kind < 8) begin
            send(fec_pkg::ACT_DUMP, $urandom, $urandom, gap_length());
         end else if (kind < 25) begin
            send(fec_pkg::ACT_LOAD, cursor, len, gap_length());
            cursor = cursor + len + $urandom_range(0, 1) * $urandom_range(0, 8);
         end else if (kind < 90) begin
            pos = cursor + $urandom_range(0, 3) * 16 - 24;
            if ($urandom_range(0, 7) == 0) pos = $urandom;
            send(fec_pkg::ACT_FREE, pos, len, gap_length());
         end else if (kind < 93) begin
            send(fec_pkg::ACT_UNUSED, $urandom, $urandom, gap_length());
         end else begin
            send(fec_pkg::ACT_FREE, $urandom, $urandom, gap_length());
         end
      end
      send(fec_pkg::ACT_DUMP, 0, 0, 0);
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("free_extent_coalescer: match");
      else
         $display("free_extent_coalescer: mismatch");
      $finish;
   end
endmodule

`default_nettype wire

@@ files.f @@
rtl/fec_pkg.sv
rtl/fec_datapath.sv
rtl/fec_control.sv
rtl/free_extent_coalescer.sv
rtl/fec_checker.sv
test/tb.sv
